>>> rtl/core/shortcut_string_to_hid_keycode_core_macros.svh
// Assertion helpers for the RTL of the shortcut keycode core (used by sshk_back).
`ifndef SHORTCUT_STRING_TO_HID_KEYCODE_CORE_MACROS_SVH
`define SHORTCUT_STRING_TO_HID_KEYCODE_CORE_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SSHK_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define SSHK_ASSERT(lbl, prop, msg) \
  `SSHK_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/core/sshk_pkg.sv
`default_nettype none

package sshk_pkg;

  // Longest name in the tables; longer tokens never match
  localparam int NameMaxLen = 9;
  localparam int IdxW       = $clog2(NameMaxLen);

  // Character codes
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] CaseOfs = 8'h20;

  // Usage code offsets for single-character keys
  localparam logic [7:0] LetterOfs = 8'd61;  // 'A' -> 4
  localparam logic [7:0] DigitOfs  = 8'd19;  // '1' -> 30
  localparam logic [6:0] UsageZero = 7'd39;

  // A closed token as it travels from front to back
  typedef struct packed {
    logic [NameMaxLen-1:0][7:0] chars;  // chars[0] is the first character
    logic [3:0]                 len;
    logic                       ok;     // nonempty, not overflowed, short enough
    logic                       last;   // closes the string
  } tok_entry_t;

  // Head of the token queue
  typedef struct packed {
    logic       valid;
    tok_entry_t entry;
  } q_head_t;

  typedef struct packed {
    logic       is_key;
    logic [6:0] key;
    logic [3:0] mods;
  } match_t;

  // Name table entry; name text is right aligned, first character highest
  typedef struct packed {
    logic [8*NameMaxLen-1:0] name;
    logic [3:0]              len;
    logic                    is_mod;
    logic [6:0]              value;
  } name_entry_t;

  localparam int NameTabN = 62;

  localparam name_entry_t NameTab [NameTabN] = '{
    '{"CTRL", 4'd4, 1'b1, 7'h01}, '{"CONTROL", 4'd7, 1'b1, 7'h01},
    '{"SHIFT", 4'd5, 1'b1, 7'h02}, '{"ALT", 4'd3, 1'b1, 7'h04},
    '{"GUI", 4'd3, 1'b1, 7'h08}, '{"META", 4'd4, 1'b1, 7'h08},
    '{"WIN", 4'd3, 1'b1, 7'h08}, '{"CMD", 4'd3, 1'b1, 7'h08},
    '{"WINDOWS", 4'd7, 1'b1, 7'h08},
    '{"ENTER", 4'd5, 1'b0, 7'd40}, '{"RETURN", 4'd6, 1'b0, 7'd40},
    '{"ESC", 4'd3, 1'b0, 7'd41}, '{"ESCAPE", 4'd6, 1'b0, 7'd41},
    '{"BACKSPACE", 4'd9, 1'b0, 7'd42}, '{"TAB", 4'd3, 1'b0, 7'd43},
    '{"SPACE", 4'd5, 1'b0, 7'd44},
    '{"MINUS", 4'd5, 1'b0, 7'd45}, '{"-", 4'd1, 1'b0, 7'd45},
    '{"EQUAL", 4'd5, 1'b0, 7'd46}, '{"=", 4'd1, 1'b0, 7'd46},
    '{"LBRACKET", 4'd8, 1'b0, 7'd47}, '{"[", 4'd1, 1'b0, 7'd47},
    '{"RBRACKET", 4'd8, 1'b0, 7'd48}, '{"]", 4'd1, 1'b0, 7'd48},
    '{"BACKSLASH", 4'd9, 1'b0, 7'd49}, '{72'h5C, 4'd1, 1'b0, 7'd49},
    '{"SEMICOLON", 4'd9, 1'b0, 7'd51}, '{";", 4'd1, 1'b0, 7'd51},
    '{"QUOTE", 4'd5, 1'b0, 7'd52}, '{"'", 4'd1, 1'b0, 7'd52},
    '{"GRAVE", 4'd5, 1'b0, 7'd53}, '{72'h60, 4'd1, 1'b0, 7'd53},
    '{"COMMA", 4'd5, 1'b0, 7'd54}, '{",", 4'd1, 1'b0, 7'd54},
    '{"PERIOD", 4'd6, 1'b0, 7'd55}, '{".", 4'd1, 1'b0, 7'd55},
    '{"SLASH", 4'd5, 1'b0, 7'd56}, '{"/", 4'd1, 1'b0, 7'd56},
    '{"F1", 4'd2, 1'b0, 7'd58}, '{"F2", 4'd2, 1'b0, 7'd59},
    '{"F3", 4'd2, 1'b0, 7'd60}, '{"F4", 4'd2, 1'b0, 7'd61},
    '{"F5", 4'd2, 1'b0, 7'd62}, '{"F6", 4'd2, 1'b0, 7'd63},
    '{"F7", 4'd2, 1'b0, 7'd64}, '{"F8", 4'd2, 1'b0, 7'd65},
    '{"F9", 4'd2, 1'b0, 7'd66}, '{"F10", 4'd3, 1'b0, 7'd67},
    '{"F11", 4'd3, 1'b0, 7'd68}, '{"F12", 4'd3, 1'b0, 7'd69},
    '{"F13", 4'd3, 1'b0, 7'd104}, '{"F14", 4'd3, 1'b0, 7'd105},
    '{"F15", 4'd3, 1'b0, 7'd106}, '{"F16", 4'd3, 1'b0, 7'd107},
    '{"F17", 4'd3, 1'b0, 7'd108}, '{"F18", 4'd3, 1'b0, 7'd109},
    '{"F19", 4'd3, 1'b0, 7'd110}, '{"F20", 4'd3, 1'b0, 7'd111},
    '{"F21", 4'd3, 1'b0, 7'd112}, '{"F22", 4'd3, 1'b0, 7'd113},
    '{"F23", 4'd3, 1'b0, 7'd114}, '{"F24", 4'd3, 1'b0, 7'd115}
  };

  // Match one closed token against all names in parallel
  function automatic match_t sshk_match(tok_entry_t e);
    match_t     m;
    logic       eq;
    logic [7:0] c;
    int         pos;
    m   = '0;
    c   = e.chars[0];
    eq  = 1'b0;
    pos = 0;
    if (e.ok) begin
      // single letters and digits
      if (e.len == 4'd1) begin
        if (c >= ChUpA && c <= ChUpZ) begin
          m.is_key = 1'b1;
          m.key    = 7'(c - LetterOfs);
        end else if (c >= ChOne && c <= ChNine) begin
          m.is_key = 1'b1;
          m.key    = 7'(c - DigitOfs);
        end else if (c == ChZero) begin
          m.is_key = 1'b1;
          m.key    = UsageZero;
        end
      end
      // named keys, symbols and modifiers
      for (int k = 0; k < NameTabN; k++) begin
        eq = (e.len == NameTab[k].len);
        for (int i = 0; i < NameMaxLen; i++) begin
          if (i < int'(NameTab[k].len)) begin
            pos = int'(NameTab[k].len) - 1 - i;
            if (e.chars[i] != NameTab[k].name[pos*8 +: 8]) eq = 1'b0;
          end
        end
        if (eq) begin
          if (NameTab[k].is_mod) begin
            m.mods = m.mods | NameTab[k].value[3:0];
          end else begin
            m.is_key = 1'b1;
            m.key    = NameTab[k].value;
          end
        end
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sshk_front.sv
`default_nettype none

module sshk_front #(
  parameter int MAX_TOKEN_CHARS = 9
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [7:0]        char_code_i,
  input  wire logic              last_char_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output sshk_pkg::tok_entry_t   entry_o
);
  import sshk_pkg::*;

  localparam int LenW = $clog2(MAX_TOKEN_CHARS + 1);

  logic [NameMaxLen-1:0][7:0] chars_q, chars_d;
  logic [LenW-1:0]            len_q, len_d;
  logic                       ovf_q, ovf_d;
  logic [7:0]                 ch;
  logic                       is_plus, is_space, close, accept;

  assign ready_o = !q_full_i;
  assign accept  = valid_i && ready_o;

  // Fold case, append to the open token
  always_comb begin
    ch = char_code_i;
    if (char_code_i >= ChLowA && char_code_i <= ChLowZ) ch = char_code_i - CaseOfs;
    is_plus  = (ch == ChPlus);
    is_space = (ch == ChSpace);
    close    = is_plus || last_char_i;
    chars_d  = chars_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    if (!is_plus && !is_space) begin
      if (len_q < LenW'(MAX_TOKEN_CHARS)) begin
        if (len_q < LenW'(NameMaxLen)) chars_d[len_q[IdxW-1:0]] = ch;
        len_d = len_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  // Closed token beat toward the queue
  always_comb begin
    entry_o.chars = chars_d;
    entry_o.len   = len_d[3:0];
    entry_o.ok    = (len_d != '0) && !ovf_d && (len_d <= LenW'(NameMaxLen));
    entry_o.last  = last_char_i;
  end
  assign push_o = accept && close;

  // Token length and overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else if (accept) begin
      if (close) begin
        len_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        len_q <= len_d;
        ovf_q <= ovf_d;
      end
    end
  end

  // Token characters
  always_ff @(posedge clk_i) begin
    if (accept) chars_q <= chars_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/sshk_queue.sv
`default_nettype none

module sshk_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire sshk_pkg::tok_entry_t entry_i,
  output logic                      full_o,
  output sshk_pkg::q_head_t         head_o,
  input  wire logic                 pop_i
);
  import sshk_pkg::*;

  tok_entry_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o       = (count_q == 2'd2);
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;
  assign head_o.valid = (count_q != 2'd0);
  assign head_o.entry = slot_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= entry_i;
  end

endmodule

`default_nettype wire

>>> rtl/core/sshk_back.sv
`default_nettype none
`include "shortcut_string_to_hid_keycode_core_macros.svh"

module sshk_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sshk_pkg::q_head_t head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [3:0]             modifier_bits_o,
  output logic [6:0]             key_usage_o
);
  import sshk_pkg::*;

  match_t     hit;
  logic [3:0] mod_q, mod_new;
  logic [6:0] key_q, key_new;
  logic       out_valid_q;
  logic [3:0] out_mod_q;
  logic [6:0] out_key_q;
  logic       pop_last;

  // Match the head token and fold it into the accumulators
  always_comb begin
    hit     = sshk_match(head_i.entry);
    mod_new = mod_q | hit.mods;
    key_new = hit.is_key ? hit.key : key_q;
  end

  // A closing token waits until the output slot frees
  assign pop_o    = head_i.valid && (!head_i.entry.last || !out_valid_q || out_ready_i);
  assign pop_last = pop_o && head_i.entry.last;

  // Accumulators and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= 4'd0;
      key_q       <= 7'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_last) begin
        mod_q <= 4'd0;
        key_q <= 7'd0;
      end else if (pop_o) begin
        mod_q <= mod_new;
        key_q <= key_new;
      end
      if (pop_last) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Result beat
  always_ff @(posedge clk_i) begin
    if (pop_last) begin
      out_mod_q <= mod_new;
      out_key_q <= key_new;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign modifier_bits_o = out_mod_q;
  assign key_usage_o     = out_key_q;

  `SSHK_ASSERT(a_last_needs_slot, pop_last |-> (!out_valid_q || out_ready_i), "result overrun")
  `SSHK_ASSERT(a_accum_cleared, pop_last |=> (mod_q == 4'd0 && key_q == 7'd0), "accum not cleared")
  `SSHK_ASSERT(a_taken_drops, (out_valid_q && out_ready_i && !pop_last) |=> !out_valid_q, "result repeated")
  `SSHK_ASSERT(a_pop_has_head, pop_o |-> head_i.valid, "pop from empty queue")

endmodule

`default_nettype wire

>>> rtl/core/shortcut_string_to_hid_keycode_core.sv
// Channel  | Dir | tdata                                  | tlast
// s_axis   | in  | [7:0] char_code                        | last_char
// m_axis   | out | [3:0] modifier_bits, [10:4] key_usage  | -
//
// One character is taken per cycle while the queue is not full. Closed tokens
// pass a two-entry queue to the matcher, which retires one token per cycle
// unless a closing token waits for the result slot. Reset clears the open
// token, the queue and the accumulators. A stalled result holds only a string
// end: other tokens keep draining, and the input stalls once the queue is full.
`default_nettype none

module shortcut_string_to_hid_keycode_core #(
  parameter int MAX_TOKEN_CHARS = 9
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tlast,   // last_char
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [3:0] modifier_bits, [10:4] key_usage
);
  import sshk_pkg::*;

  tok_entry_t push_entry;
  q_head_t    head;
  logic       push, q_full, pop;
  logic [3:0] mods;
  logic [6:0] key;

  sshk_front #(
    .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .char_code_i(s_axis_tdata),
    .last_char_i(s_axis_tlast),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  sshk_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  sshk_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .modifier_bits_o(mods),
    .key_usage_o    (key)
  );

  assign m_axis_tdata = {5'd0, key, mods};

endmodule

`default_nettype wire
